@@ rtl/core/ogg_page_deframer_assert.svh @@
// assertion macros shared by the ogg page deframer modules
`ifndef OGG_PAGE_DEFRAMER_ASSERT_SVH
`define OGG_PAGE_DEFRAMER_ASSERT_SVH

// condition implies property in the same cycle, checked out of reset
`define OGG_PD_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition implies property in the next cycle, checked out of reset
`define OGG_PD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/ogg_pd_pkg.sv @@
// types, constants and helpers shared by the ogg page deframer modules
`timescale 1ns / 1ps

package ogg_pd_pkg;

    // page header layout
    localparam logic [4:0] CountPos   = 5'd26;
    localparam logic [7:0] LaceFull   = 8'hFF;
    // lengths of nonzero packets kept per page
    localparam int unsigned PktDepth  = 255;
    localparam int unsigned PktIdxW   = 8;
    // result queue between the parser and the output port
    localparam int unsigned QueueDepth = 4;

    // parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_TABLE   = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DESC    = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    // error codes
    localparam logic ERR_CAPTURE   = 1'b0;
    localparam logic ERR_TRUNCATED = 1'b1;

    // one result beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  version;
        logic [7:0]  flags;
        logic [63:0] granule;
        logic [31:0] serial;
        logic [31:0] sequence_res;
        logic [7:0]  segment_count;
        logic [15:0] packet_length;
        logic [7:0]  payload;
        logic        packet_last;
        logic        error_code;
    } t_result;

    // up to two results from one input beat, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // expected capture pattern byte "OggS"
    function automatic logic [7:0] capture_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h4F;
            2'd1:    b = 8'h67;
            2'd2:    b = 8'h67;
            default: b = 8'h53;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/ogg_pd_parser.sv @@
// page parser: header decode, lacing table, payload marking and length store
`timescale 1ns / 1ps
`include "ogg_page_deframer_assert.svh"

module ogg_pd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_source,
    output ogg_pd_pkg::t_push o_push
);
    import ogg_pd_pkg::*;

    // parser state
    t_phase        r_phase, n_phase;
    logic [4:0]    r_hdr_pos, n_hdr_pos;
    logic [63:0]   r_granule, n_granule;
    logic [31:0]   r_serial, n_serial;
    logic [31:0]   r_sequence, n_sequence;
    logic [7:0]    r_version, n_version;
    logic [7:0]    r_flags, n_flags;
    logic [7:0]    r_seg_total, n_seg_total;
    logic [7:0]    r_tbl_idx, n_tbl_idx;
    logic [15:0]   r_lace_sum, n_lace_sum;
    logic [7:0]    r_pkt_stored, n_pkt_stored;
    logic [7:0]    r_rd_idx, n_rd_idx;
    logic [15:0]   r_bytes_left, n_bytes_left;
    logic          r_halted, n_halted;
    logic [15:0]   r_first_len, n_first_len;

    // packet length store
    logic [15:0]         mem_len [PktDepth];
    logic                wr_en;
    logic [PktIdxW-1:0]  wr_addr;
    logic [15:0]         wr_data;
    logic [PktIdxW-1:0]  rd_addr;
    logic [15:0]         r_rd_data;

    logic [15:0] sum_new;
    logic [7:0]  tbl_new;
    logic [7:0]  rd_next;
    logic        table_done;
    logic        bad_capture;
    logic        do_clear;
    logic        main_v;
    logic        trunc;
    t_result     res_main;
    t_result     res_err;

    assign sum_new = r_lace_sum + {8'd0, i_data_byte};
    assign tbl_new = r_tbl_idx + 8'd1;
    assign rd_next = r_rd_idx + 8'd1;

    // next state and results for one input beat
    always_comb begin
        n_phase      = r_phase;
        n_hdr_pos    = r_hdr_pos;
        n_granule    = r_granule;
        n_serial     = r_serial;
        n_sequence   = r_sequence;
        n_version    = r_version;
        n_flags      = r_flags;
        n_seg_total  = r_seg_total;
        n_tbl_idx    = r_tbl_idx;
        n_lace_sum   = r_lace_sum;
        n_pkt_stored = r_pkt_stored;
        n_rd_idx     = r_rd_idx;
        n_bytes_left = r_bytes_left;
        n_halted     = r_halted;
        n_first_len  = r_first_len;
        wr_en        = 1'b0;
        wr_addr      = r_pkt_stored;
        wr_data      = sum_new;
        table_done   = 1'b0;
        bad_capture  = 1'b0;
        main_v       = 1'b0;
        trunc        = 1'b0;
        res_main     = '0;
        res_err      = '0;
        res_err.kind       = KIND_ERROR;
        res_err.error_code = ERR_TRUNCATED;
        do_clear     = i_accept && i_end_of_source;

        if (i_accept && !r_halted) begin
            case (r_phase)
                PH_TABLE: begin
                    n_tbl_idx  = tbl_new;
                    n_lace_sum = sum_new;
                    table_done = (tbl_new == r_seg_total);
                    // packet ends on a short lacing value or the last entry
                    if (i_data_byte < LaceFull || table_done) begin
                        main_v                 = 1'b1;
                        res_main.kind          = KIND_DESC;
                        res_main.packet_length = sum_new;
                        if (sum_new != 16'd0 && r_pkt_stored < 8'(PktDepth)) begin
                            wr_en        = 1'b1;
                            n_pkt_stored = r_pkt_stored + 8'd1;
                            if (r_pkt_stored == 8'd0) begin
                                n_first_len = sum_new;
                            end
                        end
                        n_lace_sum = 16'd0;
                    end
                    if (table_done) begin
                        if (n_pkt_stored == 8'd0) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase      = PH_PAYLOAD;
                            n_rd_idx     = 8'd0;
                            n_bytes_left = n_first_len;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    main_v               = 1'b1;
                    res_main.kind        = KIND_PAYLOAD;
                    res_main.payload     = i_data_byte;
                    res_main.packet_last = (r_bytes_left <= 16'd1);
                    n_bytes_left = (r_bytes_left == 16'd0) ? 16'd0 : r_bytes_left - 16'd1;
                    // move to the next stored packet or back to a header
                    if (n_bytes_left == 16'd0) begin
                        n_rd_idx = rd_next;
                        if (rd_next >= r_pkt_stored) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_bytes_left = r_rd_data;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (r_hdr_pos < 5'd4) begin
                        if (i_data_byte != capture_byte(r_hdr_pos[1:0])) begin
                            bad_capture         = 1'b1;
                            main_v              = 1'b1;
                            res_main.kind       = KIND_ERROR;
                            res_main.error_code = ERR_CAPTURE;
                            n_halted            = 1'b1;
                        end
                    end else if (r_hdr_pos == 5'd4) begin
                        n_version = i_data_byte;
                    end else if (r_hdr_pos == 5'd5) begin
                        n_flags = i_data_byte;
                    end else if (r_hdr_pos < 5'd14) begin
                        n_granule = {i_data_byte, r_granule[63:8]};
                    end else if (r_hdr_pos < 5'd18) begin
                        n_serial = {i_data_byte, r_serial[31:8]};
                    end else if (r_hdr_pos < 5'd22) begin
                        n_sequence = {i_data_byte, r_sequence[31:8]};
                    end
                    if (!bad_capture) begin
                        if (r_hdr_pos < CountPos) begin
                            n_hdr_pos = r_hdr_pos + 5'd1;
                        end else begin
                            // segment count byte closes the header
                            n_seg_total            = i_data_byte;
                            main_v                 = 1'b1;
                            res_main.kind          = KIND_HEADER;
                            res_main.version       = r_version;
                            res_main.flags         = r_flags;
                            res_main.granule       = r_granule;
                            res_main.serial        = r_serial;
                            res_main.sequence_res  = r_sequence;
                            res_main.segment_count = i_data_byte;
                            n_hdr_pos    = 5'd0;
                            n_tbl_idx    = 8'd0;
                            n_lace_sum   = 16'd0;
                            n_pkt_stored = 8'd0;
                            n_rd_idx     = 8'd0;
                            n_bytes_left = 16'd0;
                            if (i_data_byte != 8'd0) begin
                                n_phase = PH_TABLE;
                            end
                        end
                    end
                end
            endcase
            // end of source inside an unfinished page
            if (i_end_of_source && !bad_capture) begin
                trunc = !(n_phase == PH_HEADER && n_hdr_pos == 5'd0);
            end
        end

        // end of source restarts parsing from scratch
        if (do_clear) begin
            n_phase      = PH_HEADER;
            n_hdr_pos    = 5'd0;
            n_granule    = 64'd0;
            n_serial     = 32'd0;
            n_sequence   = 32'd0;
            n_version    = 8'd0;
            n_flags      = 8'd0;
            n_seg_total  = 8'd0;
            n_tbl_idx    = 8'd0;
            n_lace_sum   = 16'd0;
            n_pkt_stored = 8'd0;
            n_rd_idx     = 8'd0;
            n_bytes_left = 16'd0;
            n_halted     = 1'b0;
        end
    end

    // pack results in order
    always_comb begin
        o_push = '0;
        if (main_v && trunc) begin
            o_push.count  = 2'd2;
            o_push.first  = res_main;
            o_push.second = res_err;
        end else if (main_v) begin
            o_push.count = 2'd1;
            o_push.first = res_main;
        end else if (trunc) begin
            o_push.count = 2'd1;
            o_push.first = res_err;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_pos    <= 5'd0;
            r_granule    <= 64'd0;
            r_serial     <= 32'd0;
            r_sequence   <= 32'd0;
            r_version    <= 8'd0;
            r_flags      <= 8'd0;
            r_seg_total  <= 8'd0;
            r_tbl_idx    <= 8'd0;
            r_lace_sum   <= 16'd0;
            r_pkt_stored <= 8'd0;
            r_rd_idx     <= 8'd0;
            r_bytes_left <= 16'd0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_pos    <= n_hdr_pos;
            r_granule    <= n_granule;
            r_serial     <= n_serial;
            r_sequence   <= n_sequence;
            r_version    <= n_version;
            r_flags      <= n_flags;
            r_seg_total  <= n_seg_total;
            r_tbl_idx    <= n_tbl_idx;
            r_lace_sum   <= n_lace_sum;
            r_pkt_stored <= n_pkt_stored;
            r_rd_idx     <= n_rd_idx;
            r_bytes_left <= n_bytes_left;
            r_halted     <= n_halted;
        end
    end

    // first packet length of the page, loaded when the first nonzero packet is stored
    always_ff @(posedge i_clk) begin
        r_first_len <= n_first_len;
    end

    // length store, prefetching the entry after the current packet
    assign rd_addr = n_rd_idx + 8'd1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_len[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == rd_addr) begin
            r_rd_data <= wr_data;
        end else if (rd_addr != 8'(PktDepth)) begin
            r_rd_data <= mem_len[rd_addr];
        end
    end

    // checks
    `OGG_PD_ASSERT_IMP(a_halt_in_header, r_halted, r_phase == PH_HEADER,
        "halted outside the header phase")
    `OGG_PD_ASSERT_IMP(a_payload_nonempty, r_phase == PH_PAYLOAD, r_bytes_left != 16'd0,
        "payload phase with no bytes left")
    `OGG_PD_ASSERT_IMP(a_stored_bound, r_phase == PH_TABLE, r_pkt_stored <= r_tbl_idx,
        "more packets stored than lacing values seen")

endmodule

@@ rtl/core/ogg_pd_outq.sv @@
// result queue taking up to two results a beat and giving one
`timescale 1ns / 1ps
`include "ogg_page_deframer_assert.svh"

module ogg_pd_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogg_pd_pkg::t_push   i_push,
    output logic                o_has_room,
    output logic                o_valid,
    input  logic                i_ready,
    output ogg_pd_pkg::t_result o_head
);
    import ogg_pd_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = PtrW + 1;

    t_result          entries [QueueDepth];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             pop;
    logic [PtrW-1:0]  wr_ptr_b;

    assign pop        = o_valid && i_ready;
    assign o_valid    = (r_count != '0);
    assign o_head     = entries[r_rd_ptr];
    assign o_has_room = (r_count <= CntW'(QueueDepth - 2));
    assign wr_ptr_b   = r_wr_ptr + PtrW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrW'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + PtrW'(1) : r_rd_ptr;
        n_count  = r_count + CntW'(i_push.count) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            entries[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            entries[wr_ptr_b] <= i_push.second;
        end
    end

    // checks
    `OGG_PD_ASSERT_NEXT(a_push_shows, i_push.count != 2'd0, r_count != '0,
        "pushed result not held in the queue")
    `OGG_PD_ASSERT_IMP(a_push_fits, i_push.count != 2'd0,
        (r_count + CntW'(i_push.count)) <= CntW'(QueueDepth),
        "result queue overflow")
    `OGG_PD_ASSERT_IMP(a_count_bound, r_count != '0, r_count <= CntW'(QueueDepth),
        "result queue count out of range")

endmodule

@@ rtl/core/ogg_page_deframer.sv @@
// top level of the ogg page deframer
`timescale 1ns / 1ps

// Ogg page deframer. Takes one stream byte per beat on the input channel and
// returns page headers, one length descriptor per packet, payload bytes with a
// last-of-packet mark, and errors for a bad capture pattern or a page cut off
// at end of source. A byte is parsed in the cycle it is accepted and its
// results are registered into a four-entry result queue that drives the
// output. Throughput is one byte per cycle: ready stays high while the queue
// has two free entries. A byte flagged end of source in the middle of a page
// adds a truncation error after any result of its own, so it can give two
// results, which the queue hands out at one per cycle. After a
// capture error all bytes are dropped until the next end of source; every
// end of source restarts parsing at a fresh page. CRC is not checked.
module ogg_page_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_source,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_version,
    output logic [7:0]  o_flags,
    output logic [63:0] o_granule,
    output logic [31:0] o_serial,
    output logic [31:0] o_sequence_res,
    output logic [7:0]  o_segment_count,
    output logic [15:0] o_packet_length,
    output logic [7:0]  o_payload,
    output logic        o_packet_last,
    output logic        o_error_code
);
    import ogg_pd_pkg::*;

    logic    accept;
    t_push   push;
    t_result head;

    assign accept = i_valid && o_ready;

    // byte parser
    ogg_pd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_source (i_end_of_source),
        .o_push          (push)
    );

    // result queue
    ogg_pd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_has_room (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_head     (head)
    );

    // result fields
    assign o_kind          = head.kind;
    assign o_version       = head.version;
    assign o_flags         = head.flags;
    assign o_granule       = head.granule;
    assign o_serial        = head.serial;
    assign o_sequence_res  = head.sequence_res;
    assign o_segment_count = head.segment_count;
    assign o_packet_length = head.packet_length;
    assign o_payload       = head.payload;
    assign o_packet_last   = head.packet_last;
    assign o_error_code    = head.error_code;

endmodule

@@ verif/tb_ogg_page_deframer.sv @@
// self-checking testbench for the ogg page deframer
`timescale 1ns / 1ps

module tb_ogg_page_deframer;
    import ogg_pd_pkg::*;

    localparam int          ITEM_TARGET  = 1650;
    localparam int          IDLE_PCT     = 34;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          DRAIN_LIMIT  = 50000;
    localparam logic [31:0] OGG_MAGIC    = 32'h4F676753;

    // how lacing values of a generated page are picked
    typedef enum int {
        LACE_MIXED,
        LACE_ZERO,
        LACE_BIT
    } lace_style_t;

    // how header fields of a generated page are filled
    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAND
    } fill_style_t;

    // how a generated source buffer ends
    typedef enum int {
        SRC_WHOLE,
        SRC_CUT,
        SRC_BAD_MAGIC,
        SRC_NOISE
    } source_shape_t;

    // one stream byte to send, or a marker that waits for all results
    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       hold;
        logic       calm;
    } stream_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_source = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_version;
    logic [7:0]  o_flags;
    logic [63:0] o_granule;
    logic [31:0] o_serial;
    logic [31:0] o_sequence_res;
    logic [7:0]  o_segment_count;
    logic [15:0] o_packet_length;
    logic [7:0]  o_payload;
    logic        o_packet_last;
    logic        o_error_code;

    stream_byte_t stream_q[$];
    t_result      deframed_q[$];
    logic [7:0]   page_bytes[$];
    int           live_bytes = 0;
    int           n_err = 0;
    logic         calm_now = 1'b0;

    // predictor state
    t_phase      ph;
    logic [4:0]  hdr_pos;
    logic [63:0] gran_acc;
    logic [31:0] serial_acc;
    logic [31:0] seqno_acc;
    logic [7:0]  ver_acc;
    logic [7:0]  flags_acc;
    logic [7:0]  seg_total;
    logic [7:0]  tbl_idx;
    logic [15:0] lace_acc;
    logic [15:0] pkt_len [PktDepth];
    logic [7:0]  pkt_cnt;
    logic [7:0]  rd_idx;
    logic [15:0] remain;
    logic        halted;

    ogg_page_deframer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_source (i_end_of_source),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_version       (o_version),
        .o_flags         (o_flags),
        .o_granule       (o_granule),
        .o_serial        (o_serial),
        .o_sequence_res  (o_sequence_res),
        .o_segment_count (o_segment_count),
        .o_packet_length (o_packet_length),
        .o_payload       (o_payload),
        .o_packet_last   (o_packet_last),
        .o_error_code    (o_error_code)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // back to the start of a source
    task automatic clear_parser();
        ph         = PH_HEADER;
        hdr_pos    = '0;
        gran_acc   = '0;
        serial_acc = '0;
        seqno_acc  = '0;
        ver_acc    = '0;
        flags_acc  = '0;
        seg_total  = '0;
        tbl_idx    = '0;
        lace_acc   = '0;
        pkt_cnt    = '0;
        rd_idx     = '0;
        remain     = '0;
        halted     = 1'b0;
    endtask

    // expected results of one accepted stream byte
    task automatic deframe_byte(input logic [7:0] b, input logic eos);
        t_result    r;
        logic [4:0] pos;
        logic       done;
        done = 1'b0;
        if (halted) begin
            if (eos) clear_parser();
        end else begin
            if (ph == PH_TABLE) begin
                // segment table, sum lacing values into packet lengths
                lace_acc = lace_acc + 16'(b);
                tbl_idx  = tbl_idx + 8'd1;
                if (b < LaceFull || tbl_idx == seg_total) begin
                    r = '0;
                    r.kind = KIND_DESC;
                    r.packet_length = lace_acc;
                    deframed_q.push_back(r);
                    if (lace_acc != 0 && pkt_cnt < PktDepth) begin
                        pkt_len[pkt_cnt] = lace_acc;
                        pkt_cnt = pkt_cnt + 8'd1;
                    end
                    lace_acc = '0;
                end
                if (tbl_idx == seg_total) begin
                    if (pkt_cnt == 0) begin
                        ph = PH_HEADER;
                    end else begin
                        ph     = PH_PAYLOAD;
                        rd_idx = '0;
                        remain = pkt_len[0];
                    end
                end
            end else if (ph == PH_PAYLOAD) begin
                // payload bytes with last-of-packet mark
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload = b;
                r.packet_last = (remain <= 1);
                deframed_q.push_back(r);
                remain = (remain == 0) ? 16'd0 : remain - 16'd1;
                if (remain == 0) begin
                    rd_idx = rd_idx + 8'd1;
                    if (rd_idx >= pkt_cnt || rd_idx >= PktDepth) ph = PH_HEADER;
                    else remain = pkt_len[rd_idx];
                end
            end else begin
                // page header bytes
                pos = hdr_pos;
                ph  = PH_HEADER;
                if (pos < 4) begin
                    if (b != OGG_MAGIC[8 * (3 - int'(pos)) +: 8]) begin
                        r = '0;
                        r.kind = KIND_ERROR;
                        r.error_code = ERR_CAPTURE;
                        deframed_q.push_back(r);
                        halted = 1'b1;
                        done = 1'b1;
                        if (eos) clear_parser();
                    end
                end else if (pos == 4) begin
                    ver_acc = b;
                end else if (pos == 5) begin
                    flags_acc = b;
                end else if (pos < 14) begin
                    gran_acc = {b, gran_acc[63:8]};
                end else if (pos < 18) begin
                    serial_acc = {b, serial_acc[31:8]};
                end else if (pos < 22) begin
                    seqno_acc = {b, seqno_acc[31:8]};
                end
                if (!done) begin
                    if (pos < CountPos) begin
                        hdr_pos = pos + 5'd1;
                    end else begin
                        seg_total = b;
                        r = '0;
                        r.kind = KIND_HEADER;
                        r.version = ver_acc;
                        r.flags = flags_acc;
                        r.granule = gran_acc;
                        r.serial = serial_acc;
                        r.sequence_res = seqno_acc;
                        r.segment_count = b;
                        deframed_q.push_back(r);
                        hdr_pos  = '0;
                        tbl_idx  = '0;
                        lace_acc = '0;
                        pkt_cnt  = '0;
                        rd_idx   = '0;
                        remain   = '0;
                        if (b != 0) ph = PH_TABLE;
                    end
                end
            end
            // end of source, a page left open is an error
            if (eos && !done) begin
                if (!(ph == PH_HEADER && hdr_pos == 0)) begin
                    r = '0;
                    r.kind = KIND_ERROR;
                    r.error_code = ERR_TRUNCATED;
                    deframed_q.push_back(r);
                end
                clear_parser();
            end
        end
    endtask

    task automatic report(input string name, input logic [63:0] exp_v,
                          input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s expected %0h got %0h", name, exp_v, got_v);
            n_err++;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eos, input logic calm,
                             input logic live);
        stream_q.push_back('{data: b, eos: eos, hold: 1'b0, calm: calm});
        if (live) live_bytes++;
    endtask

    task automatic push_hold();
        stream_q.push_back('{data: 8'h00, eos: 1'b0, hold: 1'b1, calm: 1'b0});
    endtask

    // one whole page into page_bytes
    task automatic build_page(input int nseg, input lace_style_t style,
                              input fill_style_t fill);
        int         total;
        int         pick;
        logic [7:0] lace;
        page_bytes.delete();
        total = 0;
        for (int i = 0; i < 4; i++) page_bytes.push_back(OGG_MAGIC[8 * (3 - i) +: 8]);
        for (int i = 4; i < 26; i++) begin
            if (fill == FILL_ZERO) page_bytes.push_back(8'h00);
            else if (fill == FILL_ONES) page_bytes.push_back(8'hFF);
            else page_bytes.push_back(8'($urandom));
        end
        page_bytes.push_back(8'(nseg));
        for (int i = 0; i < nseg; i++) begin
            case (style)
                LACE_ZERO: begin
                    lace = 8'h00;
                end
                LACE_BIT: begin
                    lace = 8'($urandom_range(0, 1));
                end
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) lace = LaceFull;
                    else if (pick == 1) lace = 8'h00;
                    else lace = 8'($urandom_range(1, 24));
                end
            endcase
            page_bytes.push_back(lace);
            total += lace;
        end
        for (int i = 0; i < total; i++) page_bytes.push_back(8'($urandom));
    endtask

    // page of random shape, mostly short tables with small packets
    task automatic random_page();
        int          pick;
        int          nseg;
        lace_style_t style;
        fill_style_t fill;
        pick = $urandom_range(0, 7);
        fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            nseg  = 255;
            style = ($urandom_range(0, 1) == 0) ? LACE_BIT : LACE_ZERO;
        end else if (pick < 12) begin
            nseg  = 0;
            style = LACE_ZERO;
        end else begin
            nseg  = $urandom_range(1, 8);
            style = ($urandom_range(0, 9) == 0) ? LACE_ZERO : LACE_MIXED;
        end
        build_page(nseg, style, fill);
    endtask

    // reset
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender, one stream byte per beat
    always @(posedge i_clk) begin : drive
        stream_byte_t nxt;
        logic         go;
        go = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (stream_q.size() > 0 && stream_q[0].hold) begin
                // pause until every expected result is out
                if (!i_valid && deframed_q.size() == 0) void'(stream_q.pop_front());
            end else if (stream_q.size() > 0) begin
                go = stream_q[0].calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
            if (go) begin
                nxt = stream_q.pop_front();
                i_valid         <= 1'b1;
                i_data_byte     <= nxt.data;
                i_end_of_source <= nxt.eos;
                calm_now        <= nxt.calm;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, compare result beats and predict from accepted bytes
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            clear_parser();
        end else begin
            if (o_valid && i_ready) begin
                if (deframed_q.size() == 0) begin
                    $error("result beat with nothing expected, kind %0d", o_kind);
                    n_err++;
                end else begin
                    want = deframed_q.pop_front();
                    report("kind", 64'(want.kind), 64'(o_kind));
                    report("version", 64'(want.version), 64'(o_version));
                    report("flags", 64'(want.flags), 64'(o_flags));
                    report("granule", want.granule, o_granule);
                    report("serial", 64'(want.serial), 64'(o_serial));
                    report("sequence_res", 64'(want.sequence_res), 64'(o_sequence_res));
                    report("segment_count", 64'(want.segment_count), 64'(o_segment_count));
                    report("packet_length", 64'(want.packet_length), 64'(o_packet_length));
                    report("payload", 64'(want.payload), 64'(o_payload));
                    report("packet_last", 64'(want.packet_last), 64'(o_packet_last));
                    report("error_code", 64'(want.error_code), 64'(o_error_code));
                end
            end
            if (i_valid && o_ready) deframe_byte(i_data_byte, i_end_of_source);
            i_ready <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // stimulus and end of run
    initial begin : stimulus
        int            src;
        int            npages;
        int            cut;
        int            bad_pos;
        int            nnoise;
        int            pick;
        int            waited;
        logic          calm;
        source_shape_t shape;

        // lone first byte of a page at end of source
        push_byte(OGG_MAGIC[31:24], 1'b1, 1'b0, 1'b1);
        // capture pattern broken on its last byte, end of source on that byte
        for (int i = 0; i < 3; i++) push_byte(OGG_MAGIC[8 * (3 - i) +: 8], 1'b0, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b0, 1'b1);
        // header-only page with all-ones fields, complete at end of source
        build_page(0, LACE_ZERO, FILL_ONES);
        foreach (page_bytes[i]) push_byte(page_bytes[i], i == page_bytes.size() - 1, 1'b0, 1'b1);
        push_hold();

        // random sources made of back-to-back pages
        src = 0;
        while (live_bytes < ITEM_TARGET) begin
            calm = (src >= 12 && src < 18);
            if (src == 30) push_hold();
            pick = $urandom_range(0, 99);
            shape = (pick < 60) ? SRC_WHOLE : (pick < 80) ? SRC_CUT :
                    (pick < 90) ? SRC_BAD_MAGIC : SRC_NOISE;
            if (shape == SRC_NOISE) begin
                nnoise = $urandom_range(1, 6);
                for (int i = 0; i < nnoise; i++)
                    push_byte(8'($urandom), i == nnoise - 1, calm, i == 0);
            end else begin
                npages = $urandom_range(1, 3);
                for (int p = 0; p < npages - 1; p++) begin
                    random_page();
                    foreach (page_bytes[i]) push_byte(page_bytes[i], 1'b0, calm, 1'b1);
                end
                random_page();
                case (shape)
                    SRC_WHOLE: begin
                        foreach (page_bytes[i])
                            push_byte(page_bytes[i], i == page_bytes.size() - 1, calm, 1'b1);
                    end
                    SRC_CUT: begin
                        cut = $urandom_range(0, page_bytes.size() - 2);
                        for (int i = 0; i <= cut; i++)
                            push_byte(page_bytes[i], i == cut, calm, 1'b1);
                    end
                    default: begin
                        // broken capture pattern, then ignored bytes up to end of source
                        bad_pos = $urandom_range(0, 3);
                        nnoise  = $urandom_range(0, 8);
                        for (int i = 0; i < bad_pos; i++)
                            push_byte(page_bytes[i], 1'b0, calm, 1'b1);
                        push_byte(page_bytes[bad_pos] ^ 8'($urandom_range(1, 255)),
                                  nnoise == 0, calm, 1'b1);
                        for (int i = 0; i < nnoise; i++)
                            push_byte(8'($urandom), i == nnoise - 1, calm, 1'b0);
                    end
                endcase
            end
            src++;
        end

        // wait for the sender, then for the last results
        @(posedge i_clk);
        while (stream_q.size() > 0 || i_valid) @(posedge i_clk);
        waited = 0;
        while (deframed_q.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (deframed_q.size() > 0) begin
            $error("%0d expected result beats never arrived", deframed_q.size());
            n_err++;
        end
        if (n_err == 0) begin
            $display("tb_ogg_page_deframer: clean");
        end else begin
            $display("tb_ogg_page_deframer: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("tb_ogg_page_deframer: errors");
        $finish;
    end

endmodule
